/* hdl/ptbg_pkg.sv */
package ptbg_pkg;

   localparam int HZ_W     = 8;
   localparam int UNITS_W  = 8;
   localparam int TENTHS_W = 5;
   localparam int PER_W    = 13;
   localparam int OP_W     = 2;
   localparam int STEP_W   = 3;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP = 2'd2;

   localparam logic REG_HZ_MIN = 1'b0;
   localparam logic REG_HZ_MAX = 1'b1;

   localparam logic [HZ_W-1:0] HZ_MIN_RESET = 8'd1;
   localparam logic [HZ_W-1:0] HZ_MAX_RESET = 8'd255;

   // x/10 as x*205 >> 11, exact for every 8-bit x
   localparam logic [HZ_W-1:0] DIV10_MUL   = 8'd205;
   localparam int              DIV10_SHIFT = 11;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [HZ_W-1:0]     hz;
      logic [TENTHS_W-1:0] hz_tenths;
      logic [UNITS_W-1:0]  units;
      logic [HZ_W-1:0]     hz_max;
   } ptbg_cmd_type;

   typedef struct packed {
      logic         valid;
      ptbg_cmd_type cmd;
   } ptbg_push_type;

   function automatic logic [TENTHS_W-1:0] div10(input logic [HZ_W-1:0] x);
      logic [2*HZ_W-1:0] prod;
      prod = {{HZ_W{1'b0}}, x} * {{HZ_W{1'b0}}, DIV10_MUL};
      return prod[DIV10_SHIFT +: TENTHS_W];
   endfunction

endpackage

/* hdl/ptbg_chan_if.sv */
interface ptbg_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptbg_pkg::OP_W-1:0]     opcode;
   logic [ptbg_pkg::HZ_W-1:0]     tone_hz;
   logic [ptbg_pkg::UNITS_W-1:0]  tone_units;

   modport source (output valid, output opcode, output tone_hz, output tone_units,
                   input ready);
   modport sink   (input valid, input opcode, input tone_hz, input tone_units,
                   output ready);
endinterface

interface ptbg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        piezo_level;
   logic                        tone_active;
   logic [ptbg_pkg::PER_W-1:0]  periods_left;

   modport source (output valid, output piezo_level, output tone_active,
                   output periods_left, input ready);
   modport sink   (input valid, input piezo_level, input tone_active,
                   input periods_left, output ready);
endinterface

/* hdl/ptbg_front.sv */
module ptbg_front (
   ptbg_req_if.sink                  req_if,
   input  logic [ptbg_pkg::HZ_W-1:0] hz_min,
   input  logic [ptbg_pkg::HZ_W-1:0] hz_max,
   input  logic                      q_full,
   output ptbg_pkg::ptbg_push_type   push
);

   logic [ptbg_pkg::HZ_W-1:0] hz_lo;
   logic [ptbg_pkg::HZ_W-1:0] hz_clamped;

   // raise to min first, then lower to max: max wins on inverted limits
   always_comb begin
      hz_lo      = (req_if.tone_hz < hz_min) ? hz_min : req_if.tone_hz;
      hz_clamped = (hz_lo > hz_max) ? hz_max : hz_lo;
      if (hz_clamped == '0) begin
         hz_clamped = ptbg_pkg::HZ_W'(1);
      end
   end

   assign req_if.ready = !q_full;

   always_comb begin
      push.valid         = req_if.valid && !q_full;
      push.cmd.opcode    = req_if.opcode;
      push.cmd.hz        = hz_clamped;
      push.cmd.hz_tenths = ptbg_pkg::div10(hz_clamped);
      push.cmd.units     = req_if.tone_units;
      push.cmd.hz_max    = hz_max;
   end

endmodule

/* hdl/ptbg_queue.sv */
module ptbg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  ptbg_pkg::ptbg_push_type push,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output ptbg_pkg::ptbg_cmd_type  head
);

   ptbg_pkg::ptbg_cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

/* hdl/ptbg_back.sv */
module ptbg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_not_empty,
   input  ptbg_pkg::ptbg_cmd_type head,
   output logic                   pop,
   ptbg_rsp_if.source             rsp_if
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DIV  = 2'b10
   } ptbg_back_state_type;

   ptbg_back_state_type state_ff, state_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ptbg_pkg::HZ_W-1:0]      timer_ff, timer_in;
   logic [ptbg_pkg::HZ_W-1:0]      reload_ff, reload_in;
   logic [ptbg_pkg::PER_W-1:0]     remaining_ff, remaining_in;
   logic                           level_ff, level_in;
   logic                           running_ff, running_in;

   // divide unit and pending burst length
   logic [ptbg_pkg::HZ_W-1:0]      rem_ff, rem_in;
   logic [ptbg_pkg::HZ_W-1:0]      quo_ff, quo_in;
   logic [ptbg_pkg::HZ_W-1:0]      dvs_ff, dvs_in;
   logic [ptbg_pkg::PER_W-1:0]     count_ff, count_in;
   logic [ptbg_pkg::STEP_W-1:0]    step_ff, step_in;

   logic                           slot_free;
   logic [ptbg_pkg::HZ_W:0]        trial;
   logic [ptbg_pkg::HZ_W-1:0]      quo_next;
   logic [ptbg_pkg::HZ_W-1:0]      reload_new;
   logic [ptbg_pkg::HZ_W-1:0]      timer_inc;
   logic [ptbg_pkg::PER_W-1:0]     remaining_dec;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      timer_in      = timer_ff;
      reload_in     = reload_ff;
      remaining_in  = remaining_ff;
      level_in      = level_ff;
      running_in    = running_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      pop           = 1'b0;
      timer_inc     = timer_ff + ptbg_pkg::HZ_W'(1);
      remaining_dec = (remaining_ff != '0) ? remaining_ff - ptbg_pkg::PER_W'(1)
                                           : remaining_ff;
      // restoring divide, one quotient bit a cycle
      trial         = {rem_ff, quo_ff[ptbg_pkg::HZ_W-1]};
      quo_next      = {quo_ff[ptbg_pkg::HZ_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_ff}) begin
         quo_next[0] = 1'b1;
      end
      reload_new    = ptbg_pkg::HZ_W'(0) - quo_next;

      case (state_ff)
         S_IDLE: begin
            if (q_not_empty && slot_free) begin
               pop = 1'b1;
               case (head.opcode)
                  ptbg_pkg::OP_TICK: begin
                     rsp_valid_in = 1'b1;
                     if (running_ff) begin
                        if (timer_inc != '0) begin
                           timer_in = timer_inc;
                        end else begin
                           timer_in = reload_ff;
                           level_in = !level_ff;
                           // falling edge ends one period
                           if (level_ff) begin
                              remaining_in = remaining_dec;
                              running_in   = (remaining_dec != '0);
                           end
                        end
                     end
                  end
                  ptbg_pkg::OP_PLAY: begin
                     state_in = S_DIV;
                     rem_in   = '0;
                     quo_in   = head.hz_max;
                     dvs_in   = head.hz;
                     step_in  = '0;
                     count_in = {{(ptbg_pkg::PER_W-ptbg_pkg::TENTHS_W){1'b0}}, head.hz_tenths}
                              * {{(ptbg_pkg::PER_W-ptbg_pkg::UNITS_W){1'b0}}, head.units};
                  end
                  ptbg_pkg::OP_STOP: begin
                     rsp_valid_in = 1'b1;
                     running_in   = 1'b0;
                     level_in     = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            rem_in  = (trial >= {1'b0, dvs_ff}) ? ptbg_pkg::HZ_W'(trial - {1'b0, dvs_ff})
                                                : trial[ptbg_pkg::HZ_W-1:0];
            quo_in  = quo_next;
            step_in = step_ff + ptbg_pkg::STEP_W'(1);
            if (step_ff == ptbg_pkg::STEP_W'(ptbg_pkg::HZ_W-1)) begin
               state_in     = S_IDLE;
               reload_in    = reload_new;
               timer_in     = reload_new;
               remaining_in = count_ff;
               running_in   = (count_ff != '0);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         timer_ff     <= '0;
         reload_ff    <= '0;
         remaining_ff <= '0;
         level_ff     <= 1'b0;
         running_ff   <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         timer_ff     <= timer_in;
         reload_ff    <= reload_in;
         remaining_ff <= remaining_in;
         level_ff     <= level_in;
         running_ff   <= running_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
   end

   // state only moves when the held beat leaves, so the result reads it directly
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.piezo_level  = level_ff;
   assign rsp_if.tone_active  = running_ff;
   assign rsp_if.periods_left = remaining_ff;

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back state not one-hot");

   a_no_beat_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !rsp_valid_ff)
      else $error("result beat pending while dividing");

   a_running_has_periods: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (remaining_ff != '0))
      else $error("burst running with no periods left");

   a_div_ends_in_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == ptbg_pkg::STEP_W'(ptbg_pkg::HZ_W-1))
      |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("divide finished without a result beat");
`endif

endmodule

/* hdl/piezo_tone_burst_generator_unit.sv */
// Piezo tone burst generator. Request beats carry an opcode: tick (one prescaled timer
// tick), play (start a burst at the clamped frequency code) or stop; every request gives
// exactly one response beat with the piezo level, the running flag and the periods left,
// in order. A two-entry command queue separates the request side from the execution side.
// Tick, stop and unused opcodes are handled directly from the idle state of the execution unit, so they
// sustain one beat per cycle while the response side takes every beat; a play beat occupies the execution
// unit for a dispatch and then the bit-serial 8-bit divide of hz_max by the frequency code, and its
// response beat is presented once that divide has ended.
// hz_min and hz_max sit at byte addresses 0 and 4 of the register port and should only
// be written while no beat is in flight.
module piezo_tone_burst_generator_unit (
   input  logic                            clock,
   input  logic                            reset,
   ptbg_req_if.sink                        req_if,
   ptbg_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ptbg_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [ptbg_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [ptbg_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);

   logic [ptbg_pkg::HZ_W-1:0] hz_min_ff, hz_min_in;
   logic [ptbg_pkg::HZ_W-1:0] hz_max_ff, hz_max_in;
   logic                      csr_write;
   logic                      csr_index;

   ptbg_pkg::ptbg_push_type   push;
   ptbg_pkg::ptbg_cmd_type    head;
   logic                      q_full;
   logic                      q_not_empty;
   logic                      pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      hz_min_in = hz_min_ff;
      hz_max_in = hz_max_ff;
      if (csr_write) begin
         case (csr_index)
            ptbg_pkg::REG_HZ_MIN: hz_min_in = csr_pwdata[ptbg_pkg::HZ_W-1:0];
            ptbg_pkg::REG_HZ_MAX: hz_max_in = csr_pwdata[ptbg_pkg::HZ_W-1:0];
            default: begin
               hz_min_in = hz_min_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ptbg_pkg::REG_HZ_MIN:
            csr_prdata = {{(ptbg_pkg::CSR_DW-ptbg_pkg::HZ_W){1'b0}}, hz_min_ff};
         ptbg_pkg::REG_HZ_MAX:
            csr_prdata = {{(ptbg_pkg::CSR_DW-ptbg_pkg::HZ_W){1'b0}}, hz_max_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_min_ff <= ptbg_pkg::HZ_MIN_RESET;
         hz_max_ff <= ptbg_pkg::HZ_MAX_RESET;
      end else begin
         hz_min_ff <= hz_min_in;
         hz_max_ff <= hz_max_in;
      end
   end

   ptbg_front u_front (
      .req_if (req_if),
      .hz_min (hz_min_ff),
      .hz_max (hz_max_ff),
      .q_full (q_full),
      .push   (push)
   );

   ptbg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   ptbg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

/* sim/tone_burst_checker.sv */
module tone_burst_checker
   import ptbg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ptbg_req_if               req_mon,
   ptbg_rsp_if               rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                pending_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             piezo_level;
      logic             tone_active;
      logic [PER_W-1:0] periods_left;
   } tone_status_type;

   logic [HZ_W-1:0]  hz_min_cfg;
   logic [HZ_W-1:0]  hz_max_cfg;
   logic [7:0]       timer_st;
   logic [7:0]       reload_st;
   logic [PER_W-1:0] periods_st;
   logic             level_st;
   logic             run_st;

   tone_status_type expected_status_q[$];
   tone_status_type got_status;
   tone_status_type want_status;

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%t %s", $realtime, msg);
   endtask

   task automatic advance_tone(input logic [OP_W-1:0] op, input logic [HZ_W-1:0] hz_req,
                               input logic [UNITS_W-1:0] units,
                               output tone_status_type status);
      logic [HZ_W-1:0] hz;
      int              quotient;
      int              reload;
      int              count;
      case (op)
         OP_TICK: begin
            if (run_st) begin
               timer_st = timer_st + 8'd1;
               if (timer_st == 8'd0) begin
                  timer_st = reload_st;
                  level_st = ~level_st;
                  // a falling edge closes one period
                  if (!level_st) begin
                     if (periods_st != '0) periods_st = periods_st - PER_W'(1);
                     if (periods_st == '0) run_st = 1'b0;
                  end
               end
            end
         end
         OP_PLAY: begin
            hz = hz_req;
            if (hz < hz_min_cfg) hz = hz_min_cfg;
            if (hz > hz_max_cfg) hz = hz_max_cfg;
            if (hz == '0) hz = 8'd1;
            quotient = int'(hz_max_cfg) / int'(hz);
            reload = 256 - quotient;
            reload_st = reload[7:0];
            count = (int'(hz) / 10) * int'(units);
            periods_st = count[PER_W-1:0];
            timer_st = reload_st;
            run_st = (periods_st != '0);
         end
         OP_STOP: begin
            run_st = 1'b0;
            level_st = 1'b0;
         end
         default: ;
      endcase
      status.piezo_level = level_st;
      status.tone_active = run_st;
      status.periods_left = periods_st;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hz_min_cfg = HZ_MIN_RESET;
         hz_max_cfg = HZ_MAX_RESET;
         timer_st = '0;
         reload_st = '0;
         periods_st = '0;
         level_st = 1'b0;
         run_st = 1'b0;
         expected_status_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_HZ_MAX) hz_max_cfg = csr_pwdata[HZ_W-1:0];
            else hz_min_cfg = csr_pwdata[HZ_W-1:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_status.piezo_level = rsp_mon.piezo_level;
            got_status.tone_active = rsp_mon.tone_active;
            got_status.periods_left = rsp_mon.periods_left;
            if (expected_status_q.size() == 0) begin
               report_failure($sformatf(
                  "unexpected response beat: level=%0d active=%0d periods=%0d",
                  got_status.piezo_level, got_status.tone_active,
                  got_status.periods_left));
            end else begin
               want_status = expected_status_q.pop_front();
               if (got_status !== want_status)
                  report_failure($sformatf(
                     {"mismatch: expected level=%0d active=%0d periods=%0d, ",
                      "got level=%0d active=%0d periods=%0d"},
                     want_status.piezo_level, want_status.tone_active, want_status.periods_left,
                     got_status.piezo_level, got_status.tone_active, got_status.periods_left));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_tone(req_mon.opcode, req_mon.tone_hz, req_mon.tone_units, want_status);
            expected_status_q.push_back(want_status);
         end
      end
      pending_beats = expected_status_q.size();
   end

endmodule

/* sim/piezo_tone_burst_generator_unit_test.sv */
module piezo_tone_burst_generator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ptbg_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int fail_count;
   int pending_beats;
   bit idle_on;
   bit hold_rsp;

   ptbg_req_if req_ch ();
   ptbg_rsp_if rsp_ch ();

   piezo_tone_burst_generator_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tone_burst_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: random backpressure, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!idle_on || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(10, 40);
            else stall_left = $urandom_range(0, 2);
         end
      end
   end

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [HZ_W-1:0] hz,
                            input logic [UNITS_W-1:0] units);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.tone_hz <= hz;
      req_ch.tone_units <= units;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 11) == 0) gap = $urandom_range(8, 30);
         else gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic quiesce();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_beats != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [HZ_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [HZ_W-1:0] lo, input logic [HZ_W-1:0] hi);
      quiesce();
      csr_write(REG_HZ_MIN, lo);
      csr_write(REG_HZ_MAX, hi);
   endtask

   task automatic run_random_phase(input int n_items, input bit with_hold);
      int                 tick_run;
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [HZ_W-1:0]    hz;
      logic [UNITS_W-1:0] units;
      tick_run = 0;
      for (int i = 0; i < n_items; i++) begin
         idle_on = ((i / 90) % 3) != 1;
         if (with_hold && i == n_items / 2) hold_rsp = 1'b1;
         hz = HZ_W'($urandom);
         if ($urandom_range(0, 9) < 7) units = UNITS_W'($urandom_range(0, 3));
         else units = UNITS_W'($urandom);
         // bursts need a run of ticks after the play to reach their end
         if (tick_run > 0) begin
            op = OP_TICK;
            tick_run--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) op = OP_TICK;
            else if (pick < 80) op = OP_PLAY;
            else if (pick < 93) op = OP_STOP;
            else op = OP_SPARE;
            if (op == OP_PLAY && $urandom_range(0, 1) == 1) tick_run = $urandom_range(4, 80);
         end
         idle_gap();
         send_beat(op, hz, units);
      end
   endtask

   initial begin
      reset = 1'b1;
      idle_on = 1'b0;
      hold_rsp = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_TICK;
      req_ch.tone_hz = '0;
      req_ch.tone_units = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset limits: idle opcodes, zero count, full-length burst, restart
      send_beat(OP_TICK, 8'hFF, 8'hFF);
      send_beat(OP_SPARE, 8'hAA, 8'h55);
      send_beat(OP_STOP, 8'h00, 8'h00);
      send_beat(OP_PLAY, 8'd0, 8'd255);
      send_beat(OP_PLAY, 8'd255, 8'd255);
      repeat (4) send_beat(OP_TICK, 8'h55, 8'hAA);
      send_beat(OP_PLAY, 8'd100, 8'd1);
      repeat (2) send_beat(OP_TICK, 8'h00, 8'h00);
      send_beat(OP_STOP, 8'hFF, 8'hFF);
      send_beat(OP_TICK, 8'h00, 8'h00);

      // inverted limits: the upper one wins
      set_limits(8'd200, 8'd50);
      send_beat(OP_PLAY, 8'd0, 8'd1);
      repeat (2) send_beat(OP_TICK, 8'h00, 8'h00);
      send_beat(OP_STOP, 8'h00, 8'h00);

      // one-period burst that runs out, then a tick while idle
      set_limits(8'd10, 8'd10);
      send_beat(OP_PLAY, 8'd255, 8'd1);
      repeat (3) send_beat(OP_TICK, 8'h00, 8'h00);
      send_beat(OP_PLAY, 8'd10, 8'd0);

      set_limits(8'd1, 8'd255);
      run_random_phase(275, 1'b0);
      set_limits(8'd255, 8'd255);
      run_random_phase(275, 1'b1);
      set_limits(8'd200, 8'd50);
      run_random_phase(275, 1'b0);
      set_limits(8'd10, 8'd20);
      run_random_phase(275, 1'b0);
      set_limits(8'd1, 8'd1);
      run_random_phase(275, 1'b0);
      set_limits(8'd1, 8'd30);
      run_random_phase(275, 1'b1);
      set_limits(8'd20, 8'd255);
      run_random_phase(275, 1'b0);

      quiesce();
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* piezo_tone_burst_generator_unit.f */
hdl/ptbg_pkg.sv
hdl/ptbg_chan_if.sv
hdl/ptbg_front.sv
hdl/ptbg_queue.sv
hdl/ptbg_back.sv
hdl/piezo_tone_burst_generator_unit.sv
sim/tone_burst_checker.sv
sim/piezo_tone_burst_generator_unit_test.sv
